### hw/rtl/qfe_pkg.sv
`default_nettype none

package qfe_pkg;

  // Channel counts: lanes built versus sample fields on the ports
  localparam int CHANNELS = 2;
  localparam int OUT_CH   = 2;

  // Field and datapath widths
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 16;
  localparam int HOLD_W   = 28;
  localparam int CNT_W    = 29;
  localparam int NUM_W    = 2 * LEN_W;
  localparam int PROD_W   = SAMPLE_W + NUM_W;
  localparam int STEP_W   = $clog2(SAMPLE_W);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = HOLD_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(20);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FADE_IN  = 2'd0,
    CFG_FADE_LEN = 2'd1,
    CFG_HOLD     = 2'd2
  } cfg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Shared command from the sequencer to every lane
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
  } lane_cmd_t;

  // Lane status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

`default_nettype wire

### hw/rtl/qfe_if.sv
`default_nettype none

// Frame request channel
interface qfe_frame_if;
  import qfe_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_ch0;
  sample_t sample_ch1;
  logic    first_frame;
  logic    source_last;

  modport source (output valid, sample_ch0, sample_ch1, first_frame, source_last,
                  input ready);
  modport sink   (input valid, sample_ch0, sample_ch1, first_frame, source_last,
                  output ready);
endinterface

// Result request channel
interface qfe_result_if;
  import qfe_pkg::*;
  logic    valid;
  logic    ready;
  sample_t out_ch0;
  sample_t out_ch1;
  logic    last;

  modport source (output valid, out_ch0, out_ch1, last, input ready);
  modport sink   (input valid, out_ch0, out_ch1, last, output ready);
endinterface

// Configuration write channel
interface qfe_cfg_if;
  import qfe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/quadratic_fade_envelope_core.sv
// Each frame passes S_CALC1, S_CALC2 and S_CALC3, then a fade-in gain pass when
// fade-in is on and a fade-out gain pass, then S_EMIT; a new frame is taken only
// in S_IDLE. Each gain pass runs the lanes' 16-step restoring divider.
// Dropped frames (slice over, no restart) are accepted in S_IDLE and discarded.
// Reset (rst, synchronous): fade-in off, fade length 20, hold 0, frame
// count 0, no slice active, output empty.
`default_nettype none

module quadratic_fade_envelope_core (
  input  logic clk,
  input  logic rst,
  qfe_frame_if.sink    samples,
  qfe_result_if.source results,
  qfe_cfg_if.sink      cfg
);
  import qfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CALC1, S_CALC2, S_CALC3,
    S_START_IN, S_WAIT_IN, S_START_OUT, S_WAIT_OUT, S_EMIT
  } state_t;

  // Configuration registers
  logic             fade_in_enable;
  logic [LEN_W-1:0] fade_len;
  logic [HOLD_W-1:0] hold_length;

  // Envelope state and work registers
  state_t           state;
  logic [CNT_W-1:0] frame_count;
  logic             slice_done;
  logic [CNT_W-1:0] n_q;
  logic             src_last_q;
  sample_t          smp_q [OUT_CH];
  logic [LEN_W-1:0] len_q;
  logic [CNT_W-1:0] end_q;
  logic [LEN_W-1:0] jin_q;
  logic [LEN_W-1:0] kout_q;
  logic             last_q;
  logic [NUM_W-1:0] num_in_q;
  logic [NUM_W-1:0] num_out_q;
  logic [NUM_W-1:0] den_q;

  // Output register
  logic    out_valid;
  sample_t out_ch0;
  sample_t out_ch1;
  logic    out_last;

  logic [LEN_W-1:0] len_eff;
  logic [CNT_W-1:0] len_x;
  logic [CNT_W-1:0] diff;
  logic [LEN_W-1:0] jin;
  logic [LEN_W-1:0] kout;
  logic             last_now;
  logic [LEN_W:0]   din;
  logic [LEN_W:0]   dout;
  logic             accept;
  logic             emit_go;

  lane_cmd_t  cmd;
  lane_stat_t lane_stat [OUT_CH];
  sample_t    lane_res  [OUT_CH];
  sample_t    lane_in   [OUT_CH];

  // Configuration writes, ready whenever out of reset
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_in_enable <= 1'b0;
      fade_len       <= LEN_RESET;
      hold_length    <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FADE_IN:  fade_in_enable <= cfg.data[0];
        CFG_FADE_LEN: fade_len       <= cfg.data[LEN_W-1:0];
        CFG_HOLD:     hold_length    <= cfg.data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Gain positions: j for fade-in, k for fade-out, and the end-of-slice flag
  assign len_eff  = (fade_len == '0) ? LEN_W'(1) : fade_len;
  assign len_x    = CNT_W'(len_q);
  assign diff     = end_q - n_q;
  assign jin      = (n_q < len_x) ? n_q[LEN_W-1:0] : len_q;
  assign kout     = (n_q >= end_q) ? '0 : ((diff > len_x) ? len_q : diff[LEN_W-1:0]);
  assign last_now = src_last_q || ({1'b0, n_q} + (CNT_W+1)'(1) >= {1'b0, end_q});
  assign din      = {len_q, 1'b0} - {1'b0, jin_q};
  assign dout     = {len_q, 1'b0} - {1'b0, kout_q};

  // Lane command and per-lane sample source
  assign cmd.start = (state == S_START_IN) || (state == S_START_OUT);
  assign cmd.num   = (state == S_START_IN) ? num_in_q : num_out_q;

  always_comb begin
    for (int c = 0; c < OUT_CH; c++) begin
      lane_in[c] = (state == S_START_OUT && fade_in_enable) ? lane_res[c] : smp_q[c];
    end
  end

  for (genvar c = 0; c < OUT_CH; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      qfe_lane u_lane (
        .clk    (clk),
        .rst    (rst),
        .cmd    (cmd),
        .sample (lane_in[c]),
        .den    (den_q),
        .stat   (lane_stat[c]),
        .result (lane_res[c])
      );
    end else begin : g_off
      assign lane_res[c]  = '0;
      assign lane_stat[c] = '0;
    end
  end

  // Handshakes
  assign samples.ready   = !rst && (state == S_IDLE);
  assign accept          = samples.valid && samples.ready;
  assign emit_go         = (state == S_EMIT) && (!out_valid || results.ready);
  assign results.valid   = out_valid;
  assign results.out_ch0 = out_ch0;
  assign results.out_ch1 = out_ch1;
  assign results.last    = out_last;

  // Sequencer and merge register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_count <= '0;
      slice_done  <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      // Output register: load on emit, clear once taken
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (samples.first_frame || !slice_done)) begin
            n_q        <= samples.first_frame ? '0 : frame_count;
            src_last_q <= samples.source_last;
            smp_q[0]   <= samples.sample_ch0;
            smp_q[1]   <= samples.sample_ch1;
            state      <= S_CALC1;
          end
        end
        S_CALC1: begin
          len_q <= len_eff;
          end_q <= CNT_W'(hold_length) + CNT_W'(len_eff);
          state <= S_CALC2;
        end
        S_CALC2: begin
          jin_q       <= jin;
          kout_q      <= kout;
          last_q      <= last_now;
          slice_done  <= last_now;
          frame_count <= (n_q == COUNT_MAX) ? n_q : n_q + CNT_W'(1);
          state       <= S_CALC3;
        end
        S_CALC3: begin
          num_in_q  <= NUM_W'(jin_q) * NUM_W'(din);
          num_out_q <= NUM_W'(kout_q) * NUM_W'(dout);
          den_q     <= NUM_W'(len_q) * NUM_W'(len_q);
          state     <= fade_in_enable ? S_START_IN : S_START_OUT;
        end
        S_START_IN: begin
          state <= S_WAIT_IN;
        end
        S_WAIT_IN: begin
          if (lane_stat[0].done) begin
            state <= S_START_OUT;
          end
        end
        S_START_OUT: begin
          state <= S_WAIT_OUT;
        end
        S_WAIT_OUT: begin
          if (lane_stat[0].done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_ch0   <= lane_res[0];
            out_ch1   <= lane_res[1];
            out_last  <= last_q;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Lanes only finish while the sequencer waits for them
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    lane_stat[0].done |-> (state == S_WAIT_IN || state == S_WAIT_OUT))
    else $error("lane finished outside a wait state");

  // A frame after the slice end without restart is dropped
  a_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && slice_done && !samples.first_frame) |=> (state == S_IDLE))
    else $error("frame after slice end was not dropped");

  // Slice end flag follows the computed last marker
  a_slice_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC2) |=> (slice_done == last_q))
    else $error("slice_done does not match last marker");

  // Lanes are idle whenever a new frame may be taken
  a_lane_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !lane_stat[0].busy)
    else $error("lane busy while sequencer idle");

endmodule

`default_nettype wire

### hw/rtl/qfe_lane.sv
`default_nettype none

// One channel lane: |s| * num, restoring divide by den, round half to even.
module qfe_lane (
  input  logic               clk,
  input  logic               rst,
  input  qfe_pkg::lane_cmd_t cmd,
  input  qfe_pkg::sample_t   sample,
  input  logic [qfe_pkg::NUM_W-1:0] den,
  output qfe_pkg::lane_stat_t stat,
  output qfe_pkg::sample_t   result
);
  import qfe_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_RND} lstate_t;

  lstate_t             state;
  logic                neg;
  logic [SAMPLE_W-1:0] mag;
  logic [NUM_W-1:0]    num;
  logic [NUM_W-1:0]    rem;
  logic [SAMPLE_W-1:0] dvd;
  logic [SAMPLE_W-1:0] quo;
  logic [STEP_W-1:0]   step;
  logic                done;

  logic [SAMPLE_W-1:0] s_bits;
  logic [SAMPLE_W-1:0] mag_in;
  logic [PROD_W-1:0]   prod;
  logic [NUM_W:0]      trial;
  logic [NUM_W:0]      den_x;
  logic                fits;
  logic [NUM_W:0]      trial_sub;
  logic [NUM_W:0]      twice;
  logic                rnd_up;
  logic [SAMPLE_W-1:0] q_rnd;
  logic [SAMPLE_W-1:0] res_bits;

  // Magnitude of the incoming sample; the most negative value maps to 2^15
  assign s_bits = sample;
  assign mag_in = s_bits[SAMPLE_W-1] ? (~s_bits + SAMPLE_W'(1)) : s_bits;

  assign prod = PROD_W'(mag) * PROD_W'(num);

  // Restoring divide step, one quotient bit a cycle
  assign den_x     = {1'b0, den};
  assign trial     = {rem, dvd[SAMPLE_W-1]};
  assign fits      = (trial >= den_x);
  assign trial_sub = trial - den_x;

  // Round half to even on the final remainder
  assign twice    = {rem, 1'b0};
  assign rnd_up   = (twice > den_x) || ((twice == den_x) && quo[0]);
  assign q_rnd    = quo + SAMPLE_W'(rnd_up);
  assign res_bits = neg ? (~q_rnd + SAMPLE_W'(1)) : q_rnd;

  assign stat.busy = (state != L_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (cmd.start) begin
            neg   <= s_bits[SAMPLE_W-1];
            mag   <= mag_in;
            num   <= cmd.num;
            state <= L_MUL;
          end
        end
        L_MUL: begin
          // quotient fits 16 bits, so the top of the product is below den
          rem   <= prod[PROD_W-1:SAMPLE_W];
          dvd   <= prod[SAMPLE_W-1:0];
          quo   <= '0;
          step  <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          rem  <= fits ? trial_sub[NUM_W-1:0] : trial[NUM_W-1:0];
          dvd  <= {dvd[SAMPLE_W-2:0], 1'b0};
          quo  <= {quo[SAMPLE_W-2:0], fits};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SAMPLE_W - 1)) begin
            state <= L_RND;
          end
        end
        L_RND: begin
          result <= res_bits;
          done   <= 1'b1;
          state  <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
